// File: sv/bid_pkg.sv
// Shared types and constants for the bounded indexed deque.
// No dependencies; every other file refers to this package by scoped name.
package bid_pkg;

  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int WORD_W  = 32;
  localparam int CNT_O_W = 5;
  localparam int ST_W    = 2;
  localparam int CFG_W   = 5;
  localparam int ADDR_W  = 2;
  localparam int PDATA_W = 32;

  // request opcodes
  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] REG_MAX_ENTRIES   = 2'd0;
  localparam logic [CFG_W-1:0]  MAX_ENTRIES_RESET = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [WORD_W-1:0]  data_out;
    logic [CNT_O_W-1:0] count;
  } res_t;

endpackage

// File: sv/bounded_indexed_deque.sv
// Bounded deque with indexed insert/remove: request and result registers
// around bid_core, plus the bid_cfg register port. Depends on bid_pkg.
// Each accepted item passes the request register, then the result register; its result
//   is on the ports (done high) for one cycle.
// Throughput: one item per cycle; busy is never raised, all shifting is parallel.
// Reset (rst, synchronous): list empty, max_entries 16, no result pending.
module bounded_indexed_deque #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bid_pkg::OP_W-1:0]        opcode,
  input  logic [bid_pkg::POS_W-1:0]       position,
  input  logic [bid_pkg::WORD_W-1:0]      data_in,
  output logic                            done,
  output logic [bid_pkg::ST_W-1:0]        status,
  output logic [bid_pkg::WORD_W-1:0]      data_out,
  output logic [bid_pkg::CNT_O_W-1:0]     count,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bid_pkg::ADDR_W-1:0]      paddr,
  input  logic [bid_pkg::PDATA_W-1:0]     pwdata,
  output logic [bid_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  logic                      req_valid;
  bid_pkg::req_t             req;
  bid_pkg::res_t             res;
  logic [bid_pkg::CFG_W-1:0] max_entries;

  assign busy = 1'b0;

  bid_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_entries (max_entries)
  );

  bid_core #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req         (req),
    .max_entries (max_entries),
    .res         (res)
  );

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.opcode   <= opcode;
      req.position <= position;
      req.data_in  <= data_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      status   <= res.status;
      data_out <= res.data_out;
      count    <= res.count;
    end
  end

endmodule

// File: sv/bid_cfg.sv
// APB-style register block holding max_entries.
// Depends on bid_pkg for widths, the register map and the reset value.
module bid_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bid_pkg::ADDR_W-1:0]    paddr,
  input  logic [bid_pkg::PDATA_W-1:0]   pwdata,
  output logic [bid_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [bid_pkg::CFG_W-1:0]     max_entries
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == bid_pkg::REG_MAX_ENTRIES);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= bid_pkg::MAX_ENTRIES_RESET;
    end else if (wr_en) begin
      max_entries <= pwdata[bid_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == bid_pkg::REG_MAX_ENTRIES) begin
      prdata = {{(bid_pkg::PDATA_W-bid_pkg::CFG_W){1'b0}}, max_entries};
    end
  end

endmodule

// File: sv/bid_core.sv
// Entry array, entry count and the single-pass insert/remove datapath.
// Depends on bid_pkg for the request/result structs, opcodes and status codes.
module bid_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  bid_pkg::req_t             req,
  input  logic [bid_pkg::CFG_W-1:0] max_entries,
  output bid_pkg::res_t             res
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width: holds the count, a position and max_entries without loss
  localparam int CMP_W = CNT_W + bid_pkg::POS_W;

  logic [DATA_WIDTH-1:0] entries      [CAPACITY];
  logic [DATA_WIDTH-1:0] entries_next [CAPACITY];
  logic [DATA_WIDTH-1:0] from_below   [CAPACITY];
  logic [DATA_WIDTH-1:0] from_above   [CAPACITY];
  logic [CNT_W-1:0]      entry_count, entry_count_next;

  logic [CMP_W-1:0] cnt_w, pos_w, max_w, cap_w, ins_pos, rem_pos;
  logic             is_ins, is_rem, ins_full, ins_bad, rem_bad, ins_ok, rem_ok;
  logic [DATA_WIDTH-1:0]                   wr_word, rd_word;
  logic [DATA_WIDTH+bid_pkg::WORD_W-1:0]   din_ext;
  logic [DATA_WIDTH+bid_pkg::WORD_W-1:0]   rd_ext;
  logic [CNT_W+bid_pkg::CNT_O_W-1:0]       cnt_ext;

  // neighbor taps for shifting; ends of the array keep their own value
  for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign from_below[g] = entries[g];
    end else begin : g_mid_lo
      assign from_below[g] = entries[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign from_above[g] = entries[g];
    end else begin : g_mid_hi
      assign from_above[g] = entries[g+1];
    end
  end

  always_comb begin
    cnt_w = CMP_W'(entry_count);
    pos_w = CMP_W'(req.position);
    max_w = CMP_W'(max_entries);
    cap_w = (max_w > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : max_w;

    is_ins = (req.opcode == bid_pkg::OP_INSERT) || (req.opcode == bid_pkg::OP_PUSH_BACK) ||
             (req.opcode == bid_pkg::OP_PUSH_FRONT);
    is_rem = (req.opcode == bid_pkg::OP_REMOVE) || (req.opcode == bid_pkg::OP_POP_BACK) ||
             (req.opcode == bid_pkg::OP_POP_FRONT);

    case (req.opcode)
      bid_pkg::OP_INSERT:    ins_pos = pos_w;
      bid_pkg::OP_PUSH_BACK: ins_pos = cnt_w;
      default:               ins_pos = '0;
    endcase

    case (req.opcode)
      bid_pkg::OP_REMOVE:   rem_pos = pos_w;
      bid_pkg::OP_POP_BACK: rem_pos = cnt_w - CMP_W'(1);
      default:              rem_pos = '0;
    endcase

    ins_full = cnt_w >= cap_w;
    ins_bad  = ins_pos > cnt_w;
    // empty list fails here too, including the wrapped pop-back position
    rem_bad  = (cnt_w == '0) || (rem_pos >= cnt_w);
    ins_ok   = is_ins && !ins_full && !ins_bad;
    rem_ok   = is_rem && !rem_bad;

    din_ext = {{DATA_WIDTH{1'b0}}, req.data_in};
    wr_word = din_ext[DATA_WIDTH-1:0];
    rd_word = entries[rem_pos[IDX_W-1:0]];
    rd_ext  = {{bid_pkg::WORD_W{1'b0}}, rd_word};

    if (ins_ok) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (rem_ok) begin
      entry_count_next = entry_count - CNT_W'(1);
    end else begin
      entry_count_next = entry_count;
    end
    cnt_ext = {{bid_pkg::CNT_O_W{1'b0}}, entry_count_next};

    if (is_ins) begin
      res.status = ins_full ? bid_pkg::ST_FULL : (ins_bad ? bid_pkg::ST_BAD : bid_pkg::ST_OK);
    end else if (is_rem) begin
      res.status = rem_bad ? bid_pkg::ST_BAD : bid_pkg::ST_OK;
    end else begin
      res.status = bid_pkg::ST_BAD;
    end
    res.data_out = rem_ok ? rd_ext[bid_pkg::WORD_W-1:0] : '0;
    res.count    = cnt_ext[bid_pkg::CNT_O_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
      if (ins_ok) begin
        if (CMP_W'(i) == ins_pos) begin
          entries_next[i] = wr_word;
        end else if (CMP_W'(i) > ins_pos) begin
          entries_next[i] = from_below[i];
        end
      end else if (rem_ok && (CMP_W'(i) >= rem_pos)) begin
        entries_next[i] = from_above[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      entries <= entries_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (req_valid) begin
      entry_count <= entry_count_next;
    end
  end

endmodule

// File: sv/bid_checker.sv
// Port-level checks for bounded_indexed_deque, attached with bind below.
// Depends on bid_pkg for status codes.
module bid_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [bid_pkg::ST_W-1:0]    status,
  input logic [bid_pkg::WORD_W-1:0]  data_out,
  input logic [bid_pkg::CNT_O_W-1:0] count
);

  // every result traces back to an accepted item, through the request and result registers
  a_done_from_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted item");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == bid_pkg::ST_OK) || (status == bid_pkg::ST_FULL) ||
             (status == bid_pkg::ST_BAD))
    else $error("undefined status code");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    done && (status != bid_pkg::ST_OK) |-> (data_out == '0))
    else $error("data on a failed item");

  // back-to-back results: failures keep the count, successes move it by one
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && (status != bid_pkg::ST_OK) |-> (count == $past(count)))
    else $error("count changed on a failed item");

  a_ok_steps_count: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && (status == bid_pkg::ST_OK) |->
      (count == $past(count) + 5'd1) || (count == $past(count) - 5'd1))
    else $error("count did not step by one");

endmodule

bind bounded_indexed_deque bid_checker u_bid_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .data_out (data_out),
  .count    (count)
);

// File: tb/sv/bounded_indexed_deque_test.sv
// Self-checking testbench for bounded_indexed_deque: a directed table, then random request
// phases under several max_entries settings, checked against typed table rows or a mirror deque.
// Depends on bid_pkg and bounded_indexed_deque.
module bounded_indexed_deque_test;

  localparam int DEPTH          = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 45;

  // opcodes the block has no operation for
  localparam logic [bid_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [bid_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef logic [bid_pkg::POS_W-1:0] pos_t;
  typedef logic [bid_pkg::CFG_W-1:0] cfg_t;

  typedef struct {
    row_kind_t                   kind;
    logic [bid_pkg::OP_W-1:0]    op;
    logic [bid_pkg::POS_W-1:0]   pos;
    logic [bid_pkg::WORD_W-1:0]  data;
    bit                          typed;
    bid_pkg::res_t               want;
  } dir_row_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [bid_pkg::OP_W-1:0]      opcode;
  logic [bid_pkg::POS_W-1:0]     position;
  logic [bid_pkg::WORD_W-1:0]    data_in;
  logic                          done;
  logic [bid_pkg::ST_W-1:0]      status;
  logic [bid_pkg::WORD_W-1:0]    data_out;
  logic [bid_pkg::CNT_O_W-1:0]   count;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [bid_pkg::ADDR_W-1:0]    paddr;
  logic [bid_pkg::PDATA_W-1:0]   pwdata;
  logic [bid_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  bounded_indexed_deque dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .position(position), .data_in(data_in),
    .done(done), .status(status), .data_out(data_out), .count(count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // mirror of the deque contents and its capacity register
  logic [bid_pkg::WORD_W-1:0]  mirror_words [DEPTH];
  int unsigned                 mirror_count;
  logic [bid_pkg::CFG_W-1:0]   mirror_cap;

  bid_pkg::res_t  pending_results [$];
  dir_row_t       dir_rows [$];
  bid_pkg::res_t  oldest;
  int             errors;
  int             items_sent;
  int             results_checked;
  int             ok_seen;
  int             full_seen;
  int             bad_seen;
  int             cfg_writes;
  int             idle_cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bid_pkg::res_t predict_request(logic [bid_pkg::OP_W-1:0] op,
                                                    logic [bid_pkg::POS_W-1:0] pos,
                                                    logic [bid_pkg::WORD_W-1:0] word);
    bid_pkg::res_t r;
    int unsigned   eff;
    int unsigned   at;
    int unsigned   i;
    r.status   = bid_pkg::ST_BAD;
    r.data_out = '0;
    eff = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
    case (op)
      bid_pkg::OP_INSERT, bid_pkg::OP_PUSH_BACK, bid_pkg::OP_PUSH_FRONT: begin
        if (op == bid_pkg::OP_PUSH_BACK) at = mirror_count;
        else if (op == bid_pkg::OP_PUSH_FRONT) at = 0;
        else at = pos;
        // full wins over a bad position
        if (mirror_count >= eff) begin
          r.status = bid_pkg::ST_FULL;
        end else if (at <= mirror_count) begin
          for (i = mirror_count; i > at; i--) mirror_words[i] = mirror_words[i-1];
          mirror_words[at] = word;
          mirror_count++;
          r.status = bid_pkg::ST_OK;
        end
      end
      bid_pkg::OP_REMOVE, bid_pkg::OP_POP_BACK, bid_pkg::OP_POP_FRONT: begin
        if (op == bid_pkg::OP_POP_FRONT) at = 0;
        else if (op == bid_pkg::OP_POP_BACK) at = mirror_count - 1;  // wraps high when empty
        else at = pos;
        if (mirror_count != 0 && at < mirror_count) begin
          r.data_out = mirror_words[at];
          for (i = at; i + 1 < mirror_count; i++) mirror_words[i] = mirror_words[i+1];
          mirror_count--;
          r.status = bid_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.count = mirror_count[bid_pkg::CNT_O_W-1:0];
    return r;
  endfunction

  function automatic void add_item(logic [bid_pkg::OP_W-1:0] op,
                                   logic [bid_pkg::POS_W-1:0] pos,
                                   logic [bid_pkg::WORD_W-1:0] data);
    dir_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.pos   = pos;
    row.data  = data;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [bid_pkg::OP_W-1:0] op,
                                      logic [bid_pkg::POS_W-1:0] pos,
                                      logic [bid_pkg::WORD_W-1:0] data,
                                      logic [bid_pkg::ST_W-1:0] st,
                                      logic [bid_pkg::WORD_W-1:0] dout,
                                      logic [bid_pkg::CNT_O_W-1:0] cnt);
    dir_row_t row;
    row.kind          = ROW_ITEM;
    row.op            = op;
    row.pos           = pos;
    row.data          = data;
    row.typed         = 1'b1;
    row.want.status   = st;
    row.want.data_out = dout;
    row.want.count    = cnt;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [bid_pkg::CFG_W-1:0] v);
    dir_row_t row;
    row.kind  = ROW_CFG;
    row.op    = bid_pkg::OP_INSERT;
    row.pos   = v;
    row.data  = '0;
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  // start is left high after acceptance so back-to-back items need no toggle
  task automatic send_request(logic [bid_pkg::OP_W-1:0] op, logic [bid_pkg::POS_W-1:0] pos,
                              logic [bid_pkg::WORD_W-1:0] data, int gap, bit typed,
                              bid_pkg::res_t typed_res);
    bid_pkg::res_t predicted;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    opcode   <= op;
    position <= pos;
    data_in  <= data;
    do @(posedge clk); while (busy);
    predicted = predict_request(op, pos, data);
    if (typed) predicted = typed_res;
    pending_results.push_back(predicted);
    items_sent++;
    case (predicted.status)
      bid_pkg::ST_OK:   ok_seen++;
      bid_pkg::ST_FULL: full_seen++;
      default:          bad_seen++;
    endcase
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_entries(logic [bid_pkg::CFG_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bid_pkg::REG_MAX_ENTRIES;
    pwdata  <= {{(bid_pkg::PDATA_W-bid_pkg::CFG_W){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mirror_cap = v;
    cfg_writes++;
    @(negedge clk);
    // read back through prdata while the address still points at the register
    if (prdata !== {{(bid_pkg::PDATA_W-bid_pkg::CFG_W){1'b0}}, v}) begin
      $display("%0t: prdata mismatch, expected %0d, got %0d", $time, v, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d data %h count %0d",
                 $time, status, data_out, count);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (status !== oldest.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d", $time, oldest.status, status);
          errors++;
        end
        if (data_out !== oldest.data_out) begin
          $display("%0t: data_out mismatch, expected %h, got %h",
                   $time, oldest.data_out, data_out);
          errors++;
        end
        if (count !== oldest.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d", $time, oldest.count, count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int                          ph;
    int                          n;
    int                          gap;
    int                          fill_pct;
    bit                          burst;
    logic [bid_pkg::CFG_W-1:0]   cap;
    logic [bid_pkg::OP_W-1:0]    op;
    logic [bid_pkg::POS_W-1:0]   pos;
    logic [bid_pkg::WORD_W-1:0]  word;
    int                          pick;
    int                          phase_caps [PHASES];

    rst      = 1'b1;
    start    = 1'b0;
    opcode   = bid_pkg::OP_INSERT;
    position = '0;
    data_in  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    errors = 0; items_sent = 0; results_checked = 0;
    ok_seen = 0; full_seen = 0; bad_seen = 0; cfg_writes = 0;
    mirror_count = 0;
    mirror_cap   = bid_pkg::MAX_ENTRIES_RESET;
    phase_caps = '{16, 31, 0, 3, 1, 16, 2, 8, 0, 16};

    // empty list, unknown opcodes, bad positions, append at count, then full cases
    add_checked(bid_pkg::OP_POP_FRONT,  5'd0,  32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(bid_pkg::OP_POP_BACK,   5'd0,  32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(bid_pkg::OP_REMOVE,     5'd0,  32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(OP_SPARE_LO,            5'd0,  32'h1,        bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(OP_SPARE_HI,            5'd31, 32'hFFFFFFFF, bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(bid_pkg::OP_INSERT,     5'd1,  32'h1234,     bid_pkg::ST_BAD, 32'h0, 5'd0);
    add_checked(bid_pkg::OP_INSERT,     5'd0,  32'hFFFFFFFF, bid_pkg::ST_OK,  32'h0, 5'd1);
    add_checked(bid_pkg::OP_PUSH_BACK,  5'd7,  32'h0,        bid_pkg::ST_OK,  32'h0, 5'd2);
    add_checked(bid_pkg::OP_PUSH_FRONT, 5'd31, 32'hA5A5A5A5, bid_pkg::ST_OK,  32'h0, 5'd3);
    add_checked(bid_pkg::OP_INSERT,     5'd3,  32'h5A5A5A5A, bid_pkg::ST_OK,  32'h0, 5'd4);
    add_checked(bid_pkg::OP_REMOVE,     5'd4,  32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd4);
    add_checked(bid_pkg::OP_REMOVE,     5'd31, 32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd4);
    add_checked(bid_pkg::OP_INSERT,     5'd31, 32'h77,       bid_pkg::ST_BAD, 32'h0, 5'd4);
    add_item(bid_pkg::OP_REMOVE,     5'd1, 32'h0);
    add_item(bid_pkg::OP_POP_BACK,   5'd0, 32'h0);
    add_item(bid_pkg::OP_POP_FRONT,  5'd0, 32'h0);
    add_cfg(5'd0);
    add_checked(bid_pkg::OP_PUSH_BACK,  5'd0,  32'hDEAD0001, bid_pkg::ST_FULL, 32'h0, 5'd1);
    add_checked(bid_pkg::OP_INSERT,     5'd31, 32'hDEAD0002, bid_pkg::ST_FULL, 32'h0, 5'd1);
    add_cfg(5'd2);
    add_item(bid_pkg::OP_PUSH_FRONT, 5'd0, 32'h80000001);
    add_checked(bid_pkg::OP_PUSH_BACK,  5'd0,  32'hDEAD0003, bid_pkg::ST_FULL, 32'h0, 5'd2);
    add_cfg(5'd1);
    add_checked(bid_pkg::OP_INSERT,     5'd0,  32'hDEAD0004, bid_pkg::ST_FULL, 32'h0, 5'd2);
    add_item(bid_pkg::OP_POP_FRONT,  5'd0, 32'h0);
    add_item(bid_pkg::OP_POP_BACK,   5'd0, 32'h0);
    add_checked(bid_pkg::OP_REMOVE,     5'd0,  32'h0,        bid_pkg::ST_BAD, 32'h0, 5'd0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        wait_for_results();
        write_max_entries(dir_rows[k].pos);
      end else begin
        send_request(dir_rows[k].op, dir_rows[k].pos, dir_rows[k].data,
                     $urandom_range(0, 4), dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      cap = (ph == 8) ? cfg_t'($urandom_range(0, 31)) : cfg_t'(phase_caps[ph]);
      wait_for_results();
      write_max_entries(cap);
      fill_pct = (ph % 2 == 0) ? 70 : 30;
      burst = 1'b0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 15 == 0) burst = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) word = '0;
        else if (pick == 1) word = '1;
        else word = $urandom;
        if ($urandom_range(0, 99) < 4) begin
          op  = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
          pos = pos_t'($urandom_range(0, 31));
        end else if ($urandom_range(0, 99) < fill_pct) begin
          pick = $urandom_range(0, 2);
          op = (pick == 0) ? bid_pkg::OP_INSERT :
               (pick == 1) ? bid_pkg::OP_PUSH_BACK : bid_pkg::OP_PUSH_FRONT;
          if ($urandom_range(0, 99) < 85) pos = pos_t'($urandom_range(0, mirror_count));
          else pos = pos_t'($urandom_range(0, 31));
        end else begin
          pick = $urandom_range(0, 2);
          op = (pick == 0) ? bid_pkg::OP_REMOVE :
               (pick == 1) ? bid_pkg::OP_POP_BACK : bid_pkg::OP_POP_FRONT;
          if ($urandom_range(0, 99) < 85 && mirror_count != 0)
            pos = pos_t'($urandom_range(0, mirror_count - 1));
          else
            pos = pos_t'($urandom_range(0, 31));
        end
        gap = burst ? 0 : $urandom_range(0, 4);
        // occasionally let the pipeline empty completely
        if ($urandom_range(0, 39) == 0) wait_for_results();
        send_request(op, pos, word, gap, 1'b0, '0);
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);

    $display("Ran %0d requests (%0d ok, %0d full, %0d rejected) across %0d capacity writes.",
             items_sent, ok_seen, full_seen, bad_seen, cfg_writes);
    $display("Compared %0d results field by field, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/bid_pkg.sv
sv/bid_cfg.sv
sv/bid_core.sv
sv/bounded_indexed_deque.sv
sv/bid_checker.sv
tb/sv/bounded_indexed_deque_test.sv
